// ===== hdl/ssirs_pkg.sv =====
// Package with the shared types, codes, constants and tree sizing functions of the sorted set.
package ssirs_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int RANK_W       = 7;
  localparam int COUNT_W      = 7;
  localparam int TREE_FANIN   = 8;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_SEL_LOW  = 2'd1,
    CMD_SEL_HIGH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TREE,
    S_COMMIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] selected_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        entry_count;
  } out_item_t;

  // Data handed from one cell to the next one up the chain.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      lt;
    logic                      valid;
  } link_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic shift_en;
    logic select;
  } cell_ctrl_t;

  // Contribution of one cell to the reduction tree.
  typedef struct packed {
    logic               flag;
    logic [VALUE_W-1:0] data;
  } tap_t;

  function automatic int level_count(input int n, input int lvl);
    int c;
    c = n;
    for (int l = 0; l < lvl; l++) begin
      c = (c + TREE_FANIN - 1) / TREE_FANIN;
    end
    return c;
  endfunction

  function automatic int tree_levels(input int n);
    int c;
    int l;
    c = n;
    l = 0;
    while (c > 1) begin
      c = (c + TREE_FANIN - 1) / TREE_FANIN;
      l = l + 1;
    end
    return (l < 1) ? 1 : l;
  endfunction

endpackage

// ===== hdl/sorted_set_insert_rank_select.sv =====
// Top level of the sorted set: cell chain, reduction tree, sequencer and result register.
// The block keeps up to CAPACITY distinct signed values in ascending order in a chain of
// cells, one value per cell. An insert transaction compares its value in every cell at
// once, a select transaction marks the cell at the wanted rank, and the per-cell results
// are collected by a registered OR tree with a fan-in of eight. One transaction is
// handled at a time. Its result is registered once the taps have passed every level of
// that tree (two levels for the default capacity of 64) and is held while stalled; the
// next transaction is accepted in the cycle after the result leaves. A duplicate insert,
// an insert into a full set and a select on an empty set leave the set unchanged and are
// reported in the status field.
module sorted_set_insert_rank_select
  import ssirs_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int IW     = $clog2(CAPACITY);
  localparam int RW     = (CW > RANK_W) ? CW : RANK_W;
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int LVW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TW     = $bits(tap_t);

  state_e                    state_q, state_d;
  logic [LVW-1:0]            lvl_q, lvl_d;
  logic [CW-1:0]             count_q, count_d;
  logic [1:0]                cmd_q;
  logic signed [VALUE_W-1:0] key_q;
  logic [IW-1:0]             idx_q;
  out_item_t                 out_q, out_d;

  logic          accept;
  logic [CW-1:0] nm1;
  logic [RW-1:0] rank_ext;
  logic [RW-1:0] nm1_ext;
  logic [IW-1:0] steps;
  logic [IW-1:0] idx_d;

  cell_ctrl_t    ctrl;
  link_t         links [CAPACITY+1];
  tap_t          taps  [CAPACITY];
  logic [TW-1:0] leaves [CAPACITY];
  logic [TW-1:0] root;
  tap_t          root_tap;
  logic          is_insert;
  logic          is_select;
  logic          insert_ok;

  assign accept = in_valid_i && !in_stall_o;

  assign nm1      = count_q - CW'(1);
  assign rank_ext = RW'(in_data_i.rank);
  assign nm1_ext  = RW'(nm1);
  assign steps    = (rank_ext > nm1_ext) ? IW'(nm1) : IW'(in_data_i.rank);
  assign idx_d    = (in_data_i.command == CMD_SEL_LOW) ? steps : IW'(nm1) - steps;

  assign is_insert = (cmd_q == CMD_INSERT);
  assign is_select = (cmd_q == CMD_SEL_LOW) || (cmd_q == CMD_SEL_HIGH);
  assign root_tap  = tap_t'(root);
  assign insert_ok = is_insert && !root_tap.flag && (count_q != CW'(CAPACITY));

  assign ctrl.select   = is_select;
  assign ctrl.shift_en = (state_q == S_COMMIT) && insert_ok;

  assign links[0].value = '0;
  assign links[0].lt    = 1'b1;
  assign links[0].valid = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssirs_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .key_i     (key_q),
      .sel_idx_i (idx_q),
      .left_i    (links[i]),
      .link_o    (links[i+1]),
      .tap_o     (taps[i])
    );
    assign leaves[i] = taps[i];
  end

  ssirs_or_tree #(
    .N (CAPACITY),
    .W (TW)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaves),
    .root_o (root)
  );

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_TREE;
          lvl_d   = '0;
        end
      end
      S_TREE: begin
        if (lvl_q == LVW'(LEVELS - 1)) begin
          state_d = S_COMMIT;
        end else begin
          lvl_d = lvl_q + LVW'(1);
        end
      end
      S_COMMIT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    out_d   = out_q;
    if (state_q == S_COMMIT) begin
      out_d.selected_value = '0;
      out_d.status         = ST_OK;
      if (is_insert) begin
        if (root_tap.flag) begin
          out_d.status = ST_DUP;
        end else if (count_q == CW'(CAPACITY)) begin
          out_d.status = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end else if (is_select) begin
        if (count_q == '0) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.selected_value = root_tap.data;
        end
      end
      out_d.entry_count = COUNT_W'(count_d);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      cmd_q <= in_data_i.command;
      key_q <= in_data_i.value;
      idx_q <= idx_d;
    end
  end

endmodule

// ===== hdl/ssirs_cell.sv =====
// One storage cell of the sorted chain: holds a value, compares it and shifts it upward.
module ssirs_cell
  import ssirs_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic signed [VALUE_W-1:0] key_i,
  input  logic [IW-1:0]             sel_idx_i,
  input  link_t                     left_i,
  output link_t                     link_o,
  output tap_t                      tap_o
);

  logic signed [VALUE_W-1:0] value_q;
  logic                      valid_q;
  logic                      lt;
  logic                      eq;
  logic                      hit;

  assign lt  = valid_q && (value_q < key_i);
  assign eq  = valid_q && (value_q == key_i);
  assign hit = valid_q && (sel_idx_i == IW'(IDX));

  assign link_o.value = value_q;
  assign link_o.lt    = lt;
  assign link_o.valid = valid_q;

  always_comb begin
    if (ctrl_i.select) begin
      tap_o.flag = hit;
      tap_o.data = hit ? value_q : '0;
    end else begin
      tap_o.flag = eq;
      tap_o.data = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift_en) begin
      valid_q <= valid_q | left_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      if (!left_i.lt) begin
        value_q <= left_i.value;
      end else if (!lt) begin
        value_q <= key_i;
      end
    end
  end

endmodule

// ===== hdl/ssirs_or_tree.sv =====
// Registered OR reduction tree that gathers the cell taps into one word.
module ssirs_or_tree
  import ssirs_pkg::*;
#(
  parameter int N = 64,
  parameter int W = 33
) (
  input  logic         clk_i,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);

  localparam int LEVELS = tree_levels(N);

  logic [W-1:0] node [LEVELS+1][N];

  for (genvar j = 0; j < N; j++) begin : g_leaf
    assign node[0][j] = leaf_i[j];
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int CNT  = level_count(N, l);
    localparam int PREV = level_count(N, l - 1);
    for (genvar j = 0; j < N; j++) begin : g_node
      if (j < CNT) begin : g_used
        localparam int NK = (PREV - j * TREE_FANIN < TREE_FANIN) ?
                            (PREV - j * TREE_FANIN) : TREE_FANIN;
        always_ff @(posedge clk_i) begin
          logic [W-1:0] acc;
          acc = '0;
          for (int k = 0; k < NK; k++) begin
            acc = acc | node[l-1][j*TREE_FANIN+k];
          end
          node[l][j] <= acc;
        end
      end else begin : g_unused
        assign node[l][j] = '0;
      end
    end
  end

  assign root_o = node[LEVELS][0];

endmodule

// ===== hdl/ssirs_checker.sv =====
// Port-level checker for the sorted set and the bind that attaches it to the top level.
module ssirs_checker
  import ssirs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result transaction changed or vanished.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("Block did not hold off input while working on a transaction.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("Input accepted while a result transaction was pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("Result transaction repeated.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |->
      (out_data_o.entry_count == '0) && (out_data_o.selected_value == '0))
    else $error("Empty-set status with nonzero count or value.");

endmodule

bind sorted_set_insert_rank_select ssirs_checker u_ssirs_checker (.*);

// ===== tb/ssirs_set_monitor.sv =====
// Monitor that predicts the sorted set's answers and checks every result transaction.
module ssirs_set_monitor
  import ssirs_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        mismatch_count_o,
  output int        answers_pending_o
);

  int        held_vals [CAPACITY];
  int        held_n;
  out_item_t set_answers_q [$];
  out_item_t got_ans;
  out_item_t want_ans;

  function automatic out_item_t update_sorted_set(input in_item_t item);
    out_item_t ans;
    int        val;
    int        pos;
    int        steps;
    ans = '0;
    ans.status = ST_OK;
    val = int'(item.value);
    case (item.command)
      CMD_INSERT: begin
        pos = 0;
        while (pos < held_n && held_vals[pos] < val) pos++;
        if (pos < held_n && held_vals[pos] == val) begin
          ans.status = ST_DUP;
        end else if (held_n >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          for (int i = held_n; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = val;
          held_n++;
        end
      end
      CMD_SEL_LOW, CMD_SEL_HIGH: begin
        if (held_n == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          steps = int'(item.rank);
          if (steps > held_n - 1) steps = held_n - 1;
          if (item.command == CMD_SEL_LOW) begin
            ans.selected_value = held_vals[steps];
          end else begin
            ans.selected_value = held_vals[held_n-1-steps];
          end
        end
      end
      default: ;
    endcase
    ans.entry_count = COUNT_W'(held_n);
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_n = 0;
      set_answers_q.delete();
      answers_pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_ans = out_data_i;
        if (set_answers_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected: expected none, actual %h",
                   $time, got_ans);
          mismatch_count_o++;
        end else begin
          want_ans = set_answers_q.pop_front();
          if (got_ans.selected_value !== want_ans.selected_value) begin
            $display("%0t: selected_value expected %0d, actual %0d", $time,
                     $signed(want_ans.selected_value), $signed(got_ans.selected_value));
            mismatch_count_o++;
          end
          if (got_ans.status !== want_ans.status) begin
            $display("%0t: status expected %0d, actual %0d", $time,
                     want_ans.status, got_ans.status);
            mismatch_count_o++;
          end
          if (got_ans.entry_count !== want_ans.entry_count) begin
            $display("%0t: entry_count expected %0d, actual %0d", $time,
                     want_ans.entry_count, got_ans.entry_count);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) set_answers_q.push_back(update_sorted_set(in_data_i));
      answers_pending_o = set_answers_q.size();
    end
  end

endmodule

// ===== tb/sorted_set_insert_rank_select_tb.sv =====
// Testbench top: drives the sorted set with directed and random transactions and gives the verdict.
module sorted_set_insert_rank_select_tb;
  import ssirs_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         PHASE_ITEMS = 460;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  int                 mismatch_count;
  int                 answers_pending;
  int                 cycle_count = 0;
  int                 send_idle_pct = 29;
  int                 recv_stall_pct = 48;
  logic               hold_req = 1'b0;
  logic [VALUE_W-1:0] inserted_vals [$];

  initial begin
    forever #6 clk = ~clk;
  end

  sorted_set_insert_rank_select u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ssirs_set_monitor u_monitor (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_data),
    .mismatch_count_o  (mismatch_count),
    .answers_pending_o (answers_pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver stalls at random, except for one long hold-off that lets the block back up.
  initial begin : receiver
    int  hold_left;
    bit  held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic in_item_t make_item(input logic [1:0] command,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [RANK_W-1:0] rank);
    in_item_t item;
    item.command = command;
    item.value   = value;
    item.rank    = rank;
    return item;
  endfunction

  function automatic in_item_t random_item();
    in_item_t item;
    int       k;
    item.value = $urandom();
    k = $urandom_range(99);
    if (k < 35) item.command = CMD_INSERT;
    else if (k < 65) item.command = CMD_SEL_LOW;
    else if (k < 96) item.command = CMD_SEL_HIGH;
    else item.command = CMD_UNUSED;
    case ($urandom_range(3))
      0, 1:    item.rank = RANK_W'($urandom_range(7));
      2:       item.rank = RANK_W'($urandom_range(63));
      default: item.rank = RANK_W'($urandom_range(127));
    endcase
    if (item.command == CMD_INSERT) begin
      k = $urandom_range(9);
      if (k < 3 && inserted_vals.size() > 0) begin
        item.value = inserted_vals[$urandom_range(inserted_vals.size() - 1)];
      end else if (k == 3) begin
        case ($urandom_range(4))
          0:       item.value = 32'h8000_0000;
          1:       item.value = 32'h7fff_ffff;
          2:       item.value = '0;
          3:       item.value = '1;
          default: item.value = 32'h1;
        endcase
      end else if (k < 6) begin
        item.value = VALUE_W'($urandom_range(200) - 100);
      end
    end
    return item;
  endfunction

  task automatic send(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    if (item.command == CMD_INSERT) inserted_vals.push_back(item.value);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(make_item(CMD_SEL_LOW, '0, '0));
    send(make_item(CMD_SEL_HIGH, 32'hffff_ffff, 7'h7f));
    send(make_item(CMD_UNUSED, 32'hffff_ffff, 7'h7f));
    send(make_item(CMD_INSERT, '0, '0));
    send(make_item(CMD_INSERT, 32'h8000_0000, '0));
    send(make_item(CMD_INSERT, 32'h7fff_ffff, 7'h7f));
    send(make_item(CMD_INSERT, 32'hffff_ffff, '0));
    send(make_item(CMD_INSERT, '0, '0));
    send(make_item(CMD_INSERT, 32'h7fff_ffff, '0));
    send(make_item(CMD_INSERT, 32'h8000_0000, '0));
    send(make_item(CMD_SEL_LOW, '0, '0));
    send(make_item(CMD_SEL_HIGH, '0, '0));
    send(make_item(CMD_SEL_LOW, 32'h5555_aaaa, 7'h7f));
    send(make_item(CMD_SEL_HIGH, 32'haaaa_5555, 7'h7f));
    send(make_item(CMD_SEL_LOW, '0, 7'd2));
    send(make_item(CMD_SEL_HIGH, '0, 7'd1));
    send(make_item(CMD_SEL_LOW, '0, 7'd64));
    send(make_item(CMD_SEL_HIGH, '0, 7'd63));
    send(make_item(CMD_UNUSED, 32'h1234_5678, 7'd3));
    send(make_item(CMD_INSERT, 32'd5, '0));
    send(make_item(CMD_INSERT, 32'hffff_fffb, '0));
    send(make_item(CMD_SEL_LOW, '0, 7'd1));
    send(make_item(CMD_SEL_HIGH, '0, 7'd1));

    repeat (PHASE_ITEMS) send(random_item());

    send_idle_pct = 48;
    recv_stall_pct <= 29;
    repeat (PHASE_ITEMS) send(random_item());

    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= 1'b1;
    repeat (PHASE_ITEMS) send(random_item());

    in_valid <= 1'b0;
    while (answers_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && answers_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sorted_set_insert_rank_select.f =====
hdl/ssirs_pkg.sv
hdl/ssirs_cell.sv
hdl/ssirs_or_tree.sv
hdl/sorted_set_insert_rank_select.sv
hdl/ssirs_checker.sv
tb/ssirs_set_monitor.sv
tb/sorted_set_insert_rank_select_tb.sv
